// ===== hdl/frsa_pkg.sv =====
// ----------------------------------------------------------------------------
// frsa_pkg
// Shared types and constants of the fenced ring space allocator.
// ----------------------------------------------------------------------------
package frsa_pkg;

	// field widths
	localparam int unsigned POS_W   = 21;
	localparam int unsigned REQ_W   = 22;
	localparam int unsigned ALIGN_W = 13;
	localparam int unsigned FENCE_W = 32;
	localparam int unsigned STAT_W  = 3;

	// parameter defaults
	localparam int unsigned FENCE_DEPTH_DEF    = 16;
	localparam int unsigned RING_BYTES_MAX_DEF = 1048576;

	// actions
	localparam logic ACT_RESERVE = 1'b0;
	localparam logic ACT_COMMIT  = 1'b1;

	// result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_GRANTED    = 3'd0,
		ST_GRANT_WAIT = 3'd1,
		ST_TOO_LARGE  = 3'd2,
		ST_NO_SPACE   = 3'd3,
		ST_COMMITTED  = 3'd4,
		ST_COMMIT_ERR = 3'd5
	} status_t;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_RET_RD,
		S_RET_CHK,
		S_RET_END,
		S_FIT,
		S_FS_END,
		S_FS_CP,
		S_SCN_RD,
		S_SCN_CHK,
		S_ALN,
		S_CMT_RD,
		S_CMT_CHK,
		S_OUT
	} state_t;

endpackage

// ===== hdl/fenced_ring_space_allocator_unit.sv =====
// One item at a time: a commit reads the newest fence entry and checks it, a
// reserve that is too large goes straight to its result, and any other reserve
// walks the fence table (one entry read from the table memory and compared per
// step; the entry that stops retirement is read again by the wait search).
// The next item is taken the cycle after the result is delivered. arst_n clears
// positions and the sequencer at once, but not the fence table; no clearing pass.
// ----------------------------------------------------------------------------
// fenced_ring_space_allocator_unit
// Byte ring allocator with fence tracked retirement of consumed space.
// ----------------------------------------------------------------------------
module fenced_ring_space_allocator_unit #(
	parameter int unsigned FENCE_DEPTH    = frsa_pkg::FENCE_DEPTH_DEF,
	parameter int unsigned RING_BYTES_MAX = frsa_pkg::RING_BYTES_MAX_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [frsa_pkg::POS_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          action,
	input  logic [frsa_pkg::POS_W-1:0]    byte_count,
	input  logic [frsa_pkg::ALIGN_W-1:0]  align_bytes,
	input  logic [frsa_pkg::FENCE_W-1:0]  current_fence,
	input  logic [frsa_pkg::FENCE_W-1:0]  completed_fence,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [frsa_pkg::STAT_W-1:0]   status,
	output logic [frsa_pkg::POS_W-1:0]    offset,
	output logic [frsa_pkg::POS_W-1:0]    space,
	output logic [frsa_pkg::FENCE_W-1:0]  wait_fence
);

	localparam int unsigned IDX_W = $clog2(FENCE_DEPTH);
	localparam int unsigned CNT_W = $clog2(FENCE_DEPTH + 1);
	localparam int unsigned PW    = frsa_pkg::POS_W;
	localparam int unsigned RW    = frsa_pkg::REQ_W;
	localparam int unsigned AW    = frsa_pkg::ALIGN_W;
	localparam int unsigned FW    = frsa_pkg::FENCE_W;
	localparam logic [CNT_W:0] DEPTH_C = (CNT_W+1)'(FENCE_DEPTH);
	localparam logic [24:0]    MAX_C   = 25'(RING_BYTES_MAX);

	// ring size as used: zero acts as one, clamp to the maximum
	function automatic logic [PW-1:0] eff_size(input logic [PW-1:0] r);
		logic [PW-1:0] s;
		s = (r == '0) ? PW'(1) : r;
		if ({4'b0, s} > MAX_C) s = MAX_C[PW-1:0];
		return s;
	endfunction

	// ring index plus an offset, modulo the table depth
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] h,
			input logic [CNT_W-1:0] k);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(h) + (CNT_W+1)'(k);
		if (s >= DEPTH_C) s = s - DEPTH_C;
		return s[IDX_W-1:0];
	endfunction

	frsa_pkg::state_t state_q, state_d;

	logic [PW-1:0]    size_q;
	logic [PW-1:0]    wo_q, fs_q, cp_q;
	logic [IDX_W-1:0] head_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] n_q;
	logic [PW-1:0]    bytes_q;
	logic [AW-1:0]    a_q;
	logic [RW-1:0]    req_q;
	logic [FW-1:0]    cur_q, done_q, wait_q;
	logic [frsa_pkg::STAT_W-1:0] status_q;

	// fence table memory
	logic [FW-1:0] ids_mem [FENCE_DEPTH];
	logic [PW-1:0] offs_mem [FENCE_DEPTH];
	logic [FW-1:0] rd_id_q;
	logic [PW-1:0] rd_off_q;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	logic wr_id_en, wr_off_en;

	// input alignment reduced to its highest set bit
	logic [AW-1:0] a_in;
	always_comb begin
		a_in = AW'(1);
		for (int i = 0; i < AW; i++) begin
			if (align_bytes[i]) a_in = AW'(1) << i;
		end
	end

	logic [RW-1:0] req_in;
	assign req_in = RW'(byte_count) + RW'(a_in);

	// shared position arithmetic
	logic [RW-1:0] amask, aligned, diff;
	logic [PW-1:0] sat_end, cp_gap;
	assign amask   = RW'(a_q) - RW'(1);
	assign aligned = (RW'(wo_q) + amask) & ~amask;
	assign diff    = aligned - RW'(wo_q);
	assign sat_end = (size_q > wo_q) ? size_q - wo_q : '0;
	assign cp_gap  = (cp_q > wo_q) ? cp_q - wo_q : '0;

	// fit checks after retirement
	logic fit_a, fit_b, fit_c;
	assign fit_a = (wo_q >= cp_q) && (req_q <= RW'(sat_end));
	assign fit_b = (wo_q >= cp_q) && (req_q < RW'(cp_q));
	assign fit_c = (wo_q < cp_q) && (req_q < RW'(cp_q - wo_q));

	// candidate fence for the wait search
	logic found;
	logic [PW-1:0] n_off, n_sp, n_cp;
	always_comb begin
		found = 1'b0;
		n_off = '0;
		n_sp  = '0;
		n_cp  = rd_off_q;
		if (wo_q == rd_off_q) begin
			found = 1'b1;
			n_sp  = size_q;
			n_cp  = '0;
		end else if (wo_q > rd_off_q) begin
			if (RW'(sat_end) >= req_q) begin
				found = 1'b1;
				n_off = wo_q;
				n_sp  = size_q - wo_q;
			end else if (RW'(rd_off_q) > req_q) begin
				found = 1'b1;
				n_sp  = rd_off_q - PW'(1);
			end
		end else if (RW'(rd_off_q - wo_q) > req_q) begin
			found = 1'b1;
			n_off = wo_q;
			n_sp  = rd_off_q - wo_q - PW'(1);
		end
	end

	// commit checks
	logic [RW-1:0] wo_plus;
	logic cmt_bad, same;
	assign wo_plus = RW'(wo_q) + RW'(bytes_q);
	assign cmt_bad = (wo_plus > RW'(size_q)) || (bytes_q > fs_q);
	assign same    = (count_q != '0) && (rd_id_q == cur_q);

	// next state and memory control
	always_comb begin
		state_d   = state_q;
		rd_addr   = slot_of(head_q, n_q);
		wr_addr   = slot_of(head_q, count_q);
		wr_id_en  = 1'b0;
		wr_off_en = 1'b0;
		case (state_q)
			frsa_pkg::S_IDLE: begin
				if (in_valid) begin
					if (action == frsa_pkg::ACT_COMMIT) state_d = frsa_pkg::S_CMT_RD;
					else if (req_in > RW'(size_q)) state_d = frsa_pkg::S_OUT;
					else state_d = frsa_pkg::S_RET_RD;
				end
			end
			frsa_pkg::S_RET_RD: begin
				state_d = (n_q == count_q) ? frsa_pkg::S_RET_END : frsa_pkg::S_RET_CHK;
			end
			frsa_pkg::S_RET_CHK: begin
				state_d = (done_q >= rd_id_q) ? frsa_pkg::S_RET_RD : frsa_pkg::S_RET_END;
			end
			frsa_pkg::S_RET_END: state_d = frsa_pkg::S_FIT;
			frsa_pkg::S_FIT: begin
				if (fit_a) state_d = frsa_pkg::S_FS_END;
				else if (fit_b) state_d = frsa_pkg::S_OUT;
				else if (fit_c) state_d = frsa_pkg::S_FS_CP;
				else state_d = frsa_pkg::S_SCN_RD;
			end
			frsa_pkg::S_FS_END: state_d = frsa_pkg::S_OUT;
			frsa_pkg::S_FS_CP:  state_d = frsa_pkg::S_OUT;
			frsa_pkg::S_SCN_RD: begin
				state_d = (n_q == count_q) ? frsa_pkg::S_OUT : frsa_pkg::S_SCN_CHK;
			end
			frsa_pkg::S_SCN_CHK: begin
				if (!found) state_d = frsa_pkg::S_SCN_RD;
				else if (rd_id_q == cur_q) state_d = frsa_pkg::S_OUT;
				else state_d = frsa_pkg::S_ALN;
			end
			frsa_pkg::S_ALN: state_d = frsa_pkg::S_OUT;
			frsa_pkg::S_CMT_RD: begin
				rd_addr = slot_of(head_q, count_q - CNT_W'(1));
				state_d = cmt_bad ? frsa_pkg::S_OUT : frsa_pkg::S_CMT_CHK;
			end
			frsa_pkg::S_CMT_CHK: begin
				state_d = frsa_pkg::S_OUT;
				if (same) begin
					wr_addr   = slot_of(head_q, count_q - CNT_W'(1));
					wr_off_en = 1'b1;
				end else if (count_q < CNT_W'(FENCE_DEPTH)) begin
					wr_id_en  = 1'b1;
					wr_off_en = 1'b1;
				end
			end
			frsa_pkg::S_OUT: begin
				if (!out_stall) state_d = frsa_pkg::S_IDLE;
			end
			default: state_d = frsa_pkg::S_IDLE;
		endcase
	end

	// table memory: one read and one write port
	always_ff @(posedge clk) begin
		rd_id_q  <= ids_mem[rd_addr];
		rd_off_q <= offs_mem[rd_addr];
		if (wr_id_en) ids_mem[wr_addr] <= cur_q;
		if (wr_off_en) offs_mem[wr_addr] <= wo_plus[PW-1:0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= frsa_pkg::S_IDLE;
		else state_q <= state_d;
	end

	// datapath and table pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q   <= eff_size(MAX_C[PW-1:0]);
			wo_q     <= '0;
			fs_q     <= '0;
			cp_q     <= '0;
			head_q   <= '0;
			count_q  <= '0;
			n_q      <= '0;
			status_q <= '0;
			wait_q   <= '0;
		end else begin
			case (state_q)
				frsa_pkg::S_IDLE: begin
					if (cfg_we) begin
						size_q  <= eff_size(cfg_wdata);
						head_q  <= '0;
						count_q <= '0;
						wo_q    <= '0;
						cp_q    <= '0;
					end
					if (in_valid) begin
						n_q      <= '0;
						wait_q   <= '0;
						status_q <= frsa_pkg::ST_TOO_LARGE;
					end
				end
				frsa_pkg::S_RET_CHK: begin
					if (done_q >= rd_id_q) begin
						cp_q <= rd_off_q;
						n_q  <= n_q + CNT_W'(1);
					end
				end
				frsa_pkg::S_RET_END: begin
					if (n_q != '0) begin
						head_q  <= slot_of(head_q, n_q);
						count_q <= count_q - n_q;
						if (wo_q == cp_q) begin
							wo_q <= '0;
							cp_q <= '0;
							fs_q <= size_q;
						end
					end
					n_q <= '0;
				end
				frsa_pkg::S_FIT: begin
					status_q <= frsa_pkg::ST_GRANTED;
					if (fit_a || fit_c) begin
						wo_q <= aligned[PW-1:0];
					end else if (fit_b) begin
						wo_q <= '0;
						fs_q <= cp_q - PW'(1);
					end
				end
				frsa_pkg::S_FS_END: fs_q <= sat_end;
				frsa_pkg::S_FS_CP:  fs_q <= (cp_gap != '0) ? cp_gap - PW'(1) : '0;
				frsa_pkg::S_SCN_RD: begin
					if (n_q == count_q) status_q <= frsa_pkg::ST_NO_SPACE;
				end
				frsa_pkg::S_SCN_CHK: begin
					if (!found) begin
						n_q <= n_q + CNT_W'(1);
					end else if (rd_id_q == cur_q) begin
						status_q <= frsa_pkg::ST_NO_SPACE;
					end else begin
						status_q <= frsa_pkg::ST_GRANT_WAIT;
						wait_q   <= rd_id_q;
						if (wo_q == rd_off_q) begin
							head_q  <= slot_of(head_q, count_q);
							count_q <= '0;
						end else begin
							head_q  <= slot_of(head_q, n_q + CNT_W'(1));
							count_q <= count_q - n_q - CNT_W'(1);
						end
						wo_q <= n_off;
						fs_q <= n_sp;
						cp_q <= n_cp;
					end
				end
				frsa_pkg::S_ALN: begin
					wo_q <= aligned[PW-1:0];
					fs_q <= (RW'(fs_q) > diff) ? fs_q - diff[PW-1:0] : '0;
				end
				frsa_pkg::S_CMT_RD: begin
					status_q <= frsa_pkg::ST_COMMIT_ERR;
				end
				frsa_pkg::S_CMT_CHK: begin
					if (same || count_q < CNT_W'(FENCE_DEPTH)) begin
						status_q <= frsa_pkg::ST_COMMITTED;
						wo_q     <= wo_plus[PW-1:0];
						fs_q     <= fs_q - bytes_q;
						if (!same) count_q <= count_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// item fields held for the duration of the operation
	always_ff @(posedge clk) begin
		if (state_q == frsa_pkg::S_IDLE && in_valid) begin
			bytes_q <= byte_count;
			a_q     <= a_in;
			req_q   <= req_in;
			cur_q   <= current_fence;
			done_q  <= completed_fence;
		end
	end

	// ports
	assign in_stall   = (state_q != frsa_pkg::S_IDLE);
	assign out_valid  = (state_q == frsa_pkg::S_OUT);
	assign status     = status_q;
	assign offset     = wo_q;
	assign space      = fs_q;
	assign wait_fence = wait_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FENCE_DEPTH))
		else $error("fence count beyond table depth");

	a_wait_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q != frsa_pkg::ST_GRANT_WAIT |-> wait_q == '0)
		else $error("wait fence set without wait grant");

	a_commit_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == frsa_pkg::S_CMT_CHK && !same && count_q < CNT_W'(FENCE_DEPTH)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("new fence entry not counted");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status_q <= frsa_pkg::ST_COMMIT_ERR)
		else $error("status code out of range");

endmodule
